### design/ctwr_pkg.sv
// Shared types and constants for the clipped tile rectangle writer.
`timescale 1ns / 1ps
`default_nettype none

package ctwr_pkg;

  // Request kinds on the input tuser
  localparam logic [1:0] OP_COPY = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_FLIP = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Command kinds on the output tuser
  localparam logic [1:0] CMD_COPY = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_VREG = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_BASE_A = 1'b0;
  localparam logic REG_BASE_B = 1'b1;

  localparam logic [13:0] BASE_A_RST = 14'h1800;
  localparam logic [13:0] BASE_B_RST = 14'h1c00;

  // Row commands emitted per request at most
  localparam int MAX_ROWS = 16;
  localparam int ROWS_W   = 5;
  localparam int CNT_W    = 4;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clip;
    logic addr;
    logic emit;
  } ctwr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic visible;
    logic last_row;
    logic out_free;
  } ctwr_sts_t;

endpackage

`default_nettype wire

### design/ctwr_ctrl.sv
// Controller state machine for the clipped tile rectangle writer.
`timescale 1ns / 1ps
`default_nettype none

module ctwr_ctrl
  import ctwr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ctwr_sts_t sts,
  output ctwr_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLIP = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        // drop requests that clip away entirely and no-op requests
        cmd.addr  = 1'b1;
        state_nxt = sts.visible ? ST_ROWS : ST_IDLE;
      end
      ST_ROWS: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_row) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/ctwr_dp.sv
// Datapath: registers, clipping, address generation and output stage.
`timescale 1ns / 1ps
`default_nettype none

module ctwr_dp
  import ctwr_pkg::*;
#(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctwr_cmd_t             cmd,
  output ctwr_sts_t                  sts,
  input  wire logic [1:0]            in_op,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_kind,
  output logic                       out_last,
  output logic [OUT_DATA_W-1:0]      out_data,
  input  wire logic                  cfg_wr,
  input  wire logic                  cfg_sel,
  input  wire logic [13:0]           cfg_wdata,
  output logic [13:0]                cfg_rdata
);

  localparam int CLIP_W = 10;
  localparam logic signed [CLIP_W-1:0] COLS_S = CLIP_W'(GRID_COLS);
  localparam logic signed [CLIP_W-1:0] ROWS_S = CLIP_W'(GRID_ROWS);
  localparam logic signed [CLIP_W-1:0] MAXR_S = CLIP_W'(MAX_ROWS);
  localparam logic [13:0] COLS_STEP = 14'(GRID_COLS);

  // Configuration and table select
  logic [13:0] base_a_r, base_b_r;
  logic        bsel_r;
  logic [13:0] base;

  assign base      = bsel_r ? base_b_r : base_a_r;
  assign cfg_rdata = (cfg_sel == REG_BASE_B) ? base_b_r : base_a_r;

  // Captured request
  logic [1:0]        op_r;
  logic signed [7:0] x_r, y_r;
  logic [7:0]        w_r, h_r, fill_r;
  logic [15:0]       sbase_r;

  // Clip results
  logic [6:0]        left_r, top_r, len_r;
  logic [7:0]        dx_r, dy_r;
  logic [ROWS_W-1:0] rows_r;
  logic              vis_r;

  // Row walk
  logic [13:0]       dst_r;
  logic [15:0]       src_r;
  logic [CNT_W-1:0]  cnt_r;

  // Output register
  logic              ovalid_r;
  logic [1:0]        okind_r;
  logic              olast_r;
  logic [13:0]       odst_r;
  logic [15:0]       osrc_r;
  logic [5:0]        olen_r;
  logic [7:0]        ofill_r, oreg_r;

  // Clip arithmetic
  logic signed [CLIP_W-1:0] xs, ys, ws, hs;
  logic signed [CLIP_W-1:0] right_raw, bot_raw, right_c, bot_c, left_c, top_c;
  logic signed [CLIP_W-1:0] len_c, rows_c, dx_c, dy_c;
  logic                     vis_c;

  assign xs        = {{2{x_r[7]}}, x_r};
  assign ys        = {{2{y_r[7]}}, y_r};
  assign ws        = {2'b00, w_r};
  assign hs        = {2'b00, h_r};
  assign right_raw = xs + ws;
  assign bot_raw   = ys + hs;
  assign right_c   = (right_raw > COLS_S) ? COLS_S : right_raw;
  assign bot_c     = (bot_raw > ROWS_S) ? ROWS_S : bot_raw;
  assign left_c    = x_r[7] ? '0 : xs;
  assign top_c     = y_r[7] ? '0 : ys;
  assign len_c     = right_c - left_c;
  assign rows_c    = bot_c - top_c;
  assign dx_c      = left_c - xs;
  assign dy_c      = top_c - ys;

  always_comb begin
    case (op_r)
      OP_FLIP: vis_c = 1'b1;
      OP_NONE: vis_c = 1'b0;
      default: vis_c = (right_c > left_c) && (bot_c > top_c);
    endcase
  end

  // Row start addresses
  logic [15:0] src_prod, src_c;
  logic [13:0] dst_c;

  assign src_prod = {8'd0, dy_r} * {8'd0, w_r};
  assign src_c    = sbase_r + src_prod + {8'd0, dx_r};
  assign dst_c    = base + 14'(32'(top_r) * GRID_COLS) + {7'd0, left_r};

  logic out_free;
  assign out_free = !ovalid_r || out_ready;

  assign sts.visible  = vis_r;
  assign sts.last_row = ({1'b0, cnt_r} == rows_r - ROWS_W'(1));
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_a_r <= BASE_A_RST;
      base_b_r <= BASE_B_RST;
      bsel_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_sel == REG_BASE_A) begin
          base_a_r <= cfg_wdata;
        end else begin
          base_b_r <= cfg_wdata;
        end
      end
      if (cmd.emit && op_r == OP_FLIP) begin
        bsel_r <= ~bsel_r;
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      x_r     <= in_data[7:0];
      y_r     <= in_data[15:8];
      w_r     <= in_data[23:16];
      h_r     <= in_data[31:24];
      sbase_r <= in_data[47:32];
      fill_r  <= in_data[55:48];
    end
    if (cmd.clip) begin
      left_r <= left_c[6:0];
      top_r  <= top_c[6:0];
      len_r  <= len_c[6:0];
      dx_r   <= dx_c[7:0];
      dy_r   <= dy_c[7:0];
      vis_r  <= vis_c;
      if (op_r == OP_FLIP) begin
        rows_r <= ROWS_W'(1);
      end else if (rows_c > MAXR_S) begin
        rows_r <= ROWS_W'(MAX_ROWS);
      end else begin
        rows_r <= rows_c[ROWS_W-1:0];
      end
    end
    if (cmd.addr) begin
      dst_r <= dst_c;
      src_r <= src_c;
      cnt_r <= '0;
    end
    if (cmd.emit) begin
      dst_r   <= dst_r + COLS_STEP;
      src_r   <= src_r + {8'd0, w_r};
      cnt_r   <= cnt_r + CNT_W'(1);
      olast_r <= sts.last_row;
      case (op_r)
        OP_FLIP: begin
          okind_r <= CMD_VREG;
          odst_r  <= '0;
          osrc_r  <= '0;
          olen_r  <= '0;
          ofill_r <= '0;
          oreg_r  <= {4'd0, base[13:10]};
        end
        OP_FILL: begin
          okind_r <= CMD_FILL;
          odst_r  <= dst_r;
          osrc_r  <= '0;
          olen_r  <= len_r[5:0];
          ofill_r <= fill_r;
          oreg_r  <= '0;
        end
        default: begin
          okind_r <= CMD_COPY;
          odst_r  <= dst_r;
          osrc_r  <= src_r;
          olen_r  <= len_r[5:0];
          ofill_r <= '0;
          oreg_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_kind  = okind_r;
  assign out_last  = olast_r;
  assign out_data  = {4'd0, oreg_r, ofill_r, olen_r, osrc_r, odst_r};

endmodule

`default_nettype wire

### design/clipped_tile_rect_writer_core.sv
// Top level of the clipped tile rectangle writer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transaction
// in_*      in   one rectangle request (copy, fill, flip or none)
// out_*     out  one row command or one video register write
// cfg_*     in   APB write/read of table_base_a (0x0) and table_base_b (0x4)
//
// A request is captured in the idle state, clipped in the clip state and
// its start addresses (one 8x8 multiply for the source offset) formed in
// the address state. Rows then leave one per cycle from the output register
// while out_tready does not stall; fully clipped ones emit no rows.
// Synchronous active-low reset clears the controller, the table select
// and the output valid and loads the reset table bases.
// A stalled out_tready holds the row walk; the last command may still
// wait in the output register while the next request is taken.

module clipped_tile_rect_writer_core
  import ctwr_pkg::*;
#(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // op
  input  wire logic [1:0]            in_tuser,
  // pos_x, pos_y, rect_width, rect_height, source_base, fill_byte
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cmd_kind
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast,
  // dest_addr, src_addr, row_length, row_fill, reg_value, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [2:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  ctwr_cmd_t   cmd;
  ctwr_sts_t   sts;
  logic        cfg_wr;
  logic [13:0] cfg_rdata;

  // Register select is address bit 2; pready is tied high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {18'd0, cfg_rdata};

  ctwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctwr_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_last  (out_tlast),
    .out_data  (out_tdata),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (cfg_paddr[2]),
    .cfg_wdata (cfg_pwdata[13:0]),
    .cfg_rdata (cfg_rdata)
  );

endmodule

`default_nettype wire
